### design/mi4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg: shared types and helpers for the 4x4 matrix inverse core
// Command and status structures between controller and datapath, and the
// cofactor term table (element indices and sign of each 3x3 product).
// ----------------------------------------------------------------------------
package mi4_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int TERMS          = 6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_A,
      OP_MUL_AB,
      OP_MUL_C,
      OP_COF_WR,
      OP_MUL_D,
      OP_CHK,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       wr_en;
      logic       clr;
      logic [3:0] idx;
      logic [3:0] cidx;
      logic [1:0] part;
      logic       neg;
      logic       acc_en;
      logic       dacc_en;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic fell_back;
   } status_type;

   typedef struct packed {
      logic [3:0] a;
      logic [3:0] b;
      logic [3:0] c;
      logic       neg;
   } term_type;

   // term t of the signed cofactor k = row*4 + col
   function automatic term_type mi4_term(logic [3:0] k, logic [2:0] t);
      logic [1:0] r, c;
      logic [1:0] r0, r1, r2, c0, c1, c2;
      logic [1:0] pa, pb, pc;
      logic       odd;
      term_type   res;
      r  = k[3:2];
      c  = k[1:0];
      r0 = (r == 2'd0) ? 2'd1 : 2'd0;
      r1 = (r <= 2'd1) ? 2'd2 : 2'd1;
      r2 = (r <= 2'd2) ? 2'd3 : 2'd2;
      c0 = (c == 2'd0) ? 2'd1 : 2'd0;
      c1 = (c <= 2'd1) ? 2'd2 : 2'd1;
      c2 = (c <= 2'd2) ? 2'd3 : 2'd2;
      case (t)
         3'd0:    begin pa = c0; pb = c1; pc = c2; odd = 1'b0; end
         3'd1:    begin pa = c1; pb = c2; pc = c0; odd = 1'b0; end
         3'd2:    begin pa = c2; pb = c0; pc = c1; odd = 1'b0; end
         3'd3:    begin pa = c0; pb = c2; pc = c1; odd = 1'b1; end
         3'd4:    begin pa = c2; pb = c1; pc = c0; odd = 1'b1; end
         default: begin pa = c1; pb = c0; pc = c2; odd = 1'b1; end
      endcase
      res.a   = {r0, pa};
      res.b   = {r1, pb};
      res.c   = {r2, pc};
      res.neg = odd ^ r[0] ^ c[0];
      return res;
   endfunction

endpackage

### design/matrix_inverse_4x4_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_core: 4x4 fixed-point matrix inverse by cofactors
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: elem_value
// rsp     | out | rsp_tvalid/tready    | tdata: inv_value, inv_index;
//         |     |                      | tlast: last_elem; tuser: fell_back
// Elements load one per cycle. After the sixteenth the cofactor products run
// on one shared multiplier, then the determinant pass, the check, and the
// bit-serial divider for each result (Q16.16 by default); on fallback each
// result is taken from the identity matrix with no division.
// Reset is synchronous and clears control state only.
// A stalled result holds in the output register while the next division runs.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_core
   import mi4_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,  // elem_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DATA_WIDTH+4+7)/8)*8-1:0]   rsp_tdata,  // inv_value, inv_index
   output logic                                rsp_tlast,  // last_elem
   output logic                                rsp_tuser   // fell_back
);

   localparam int OW = ((DATA_WIDTH + 4 + 7) / 8) * 8;
   localparam int DIV_STEPS = 3 * DATA_WIDTH + 2 + FRAC_BITS;

   cmd_type                 cmd;
   status_type              status;
   logic [DATA_WIDTH-1:0]   inv_value;
   logic [3:0]              inv_index;

   mi4_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   mi4_dpath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .elem_in   (req_tdata[DATA_WIDTH-1:0]),
      .cmd       (cmd),
      .status    (status),
      .inv_value (inv_value),
      .inv_index (inv_index),
      .last_elem (rsp_tlast),
      .fell_back (rsp_tuser)
   );

   assign rsp_tdata = OW'({inv_index, inv_value});

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while held");

   // no accumulation while taking elements
   a_idle_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!cmd.acc_en && !cmd.dacc_en))
      else $error("accumulator active during load");

   // fallback identity has zeros off the diagonal
   a_ident: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && (inv_index[3:2] != inv_index[1:0]))
         |-> (inv_value == '0))
      else $error("fallback off-diagonal not zero");

endmodule

### design/mi4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_ctrl: sequencer for the 4x4 matrix inverse core
// Loads elements, steps the cofactor and determinant passes, runs the
// bit-serial divider per result and hands results to the output register.
// ----------------------------------------------------------------------------
module mi4_ctrl
   import mi4_pkg::*;
#(
   parameter int DIV_STEPS = 3 * DATA_WIDTH_DEF + 2 + FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int SW = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      S_LOAD, S_COF, S_COFWR, S_DET, S_DETEND, S_CHK, S_DIVI, S_DIV, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  k_ff, k_in;
   logic [2:0]  t_ff, t_in;
   logic [2:0]  ph_ff, ph_in;
   logic [3:0]  s_ff, s_in;
   logic [3:0]  e_ff, e_in;
   logic [SW-1:0] dcnt_ff, dcnt_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   term_type    term;

   assign term       = mi4_term(k_ff, t_ff);
   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd      = '0;
      cmd.op   = OP_NONE;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      ph_in    = ph_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      dcnt_in  = dcnt_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd.wr_en = 1'b1;
               cmd.idx   = cnt_ff;
               cnt_in    = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  cmd.clr  = 1'b1;
                  state_in = S_COF;
                  k_in     = 4'd0;
                  t_in     = 3'd0;
                  ph_in    = 3'd0;
               end
            end
         end
         S_COF: begin
            // five phases per triple product: a, a*b, lo*c, hi*c, last add
            case (ph_ff)
               3'd0: begin cmd.op = OP_LOAD_A; cmd.idx = term.a; end
               3'd1: begin cmd.op = OP_MUL_AB; cmd.idx = term.b; end
               3'd2: begin
                  cmd.op = OP_MUL_C; cmd.idx = term.c; cmd.part = 2'd0;
                  cmd.neg = term.neg;
               end
               3'd3: begin
                  cmd.op = OP_MUL_C; cmd.idx = term.c; cmd.part = 2'd1;
                  cmd.neg = term.neg; cmd.acc_en = 1'b1;
               end
               default: cmd.acc_en = 1'b1;
            endcase
            if (ph_ff == 3'd4) begin
               ph_in = 3'd0;
               if (t_ff == 3'(TERMS - 1)) begin
                  t_in     = 3'd0;
                  state_in = S_COFWR;
               end else begin
                  t_in = t_ff + 3'd1;
               end
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         S_COFWR: begin
            cmd.op   = OP_COF_WR;
            cmd.cidx = k_ff;
            k_in     = k_ff + 4'd1;
            if (k_ff == 4'd15) begin
               s_in     = 4'd0;
               state_in = S_DET;
            end else begin
               state_in = S_COF;
            end
         end
         S_DET: begin
            cmd.op      = OP_MUL_D;
            cmd.idx     = {2'b00, s_ff[3:2]};
            cmd.cidx    = {2'b00, s_ff[3:2]};
            cmd.part    = s_ff[1:0];
            cmd.dacc_en = (s_ff != 4'd0);
            s_in        = s_ff + 4'd1;
            if (s_ff == 4'd15) state_in = S_DETEND;
         end
         S_DETEND: begin
            cmd.dacc_en = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            cmd.op   = OP_CHK;
            e_in     = 4'd0;
            state_in = S_DIVI;
         end
         S_DIVI: begin
            if (status.fell_back) begin
               state_in = S_OUT;
            end else begin
               // result (i,j) takes cofactor (j,i)
               cmd.op   = OP_DIV_INIT;
               cmd.cidx = {e_ff[1:0], e_ff[3:2]};
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op  = OP_DIV_STEP;
            dcnt_in = dcnt_ff + SW'(1);
            if (dcnt_ff == SW'(DIV_STEPS - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.op   = OP_OUT;
               cmd.idx  = e_ff;
               cmd.last = (e_ff == 4'd15);
               e_in     = e_ff + 4'd1;
               state_in = (e_ff == 4'd15) ? S_LOAD : S_DIVI;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   assign rsp_tvalid_in = (cmd.op == OP_OUT) ? 1'b1 :
                          (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         cnt_ff        <= '0;
         k_ff          <= '0;
         t_ff          <= '0;
         ph_ff         <= '0;
         s_ff          <= '0;
         e_ff          <= '0;
         dcnt_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         k_ff          <= k_in;
         t_ff          <= t_in;
         ph_ff         <= ph_in;
         s_ff          <= s_in;
         e_ff          <= e_in;
         dcnt_ff       <= dcnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

### design/mi4_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_dpath: arithmetic for the 4x4 matrix inverse core
// Element and cofactor stores, one shared (D+1)xD multiplier with product
// register, cofactor and determinant accumulators, restoring divider and
// the saturating output register.
// ----------------------------------------------------------------------------
module mi4_dpath
   import mi4_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DATA_WIDTH-1:0] elem_in,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [DATA_WIDTH-1:0] inv_value,
   output logic [3:0]            inv_index,
   output logic                  last_elem,
   output logic                  fell_back
);

   localparam int D  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int CW = 3 * D + 2;
   localparam int DW = 4 * D + 3;
   localparam int NW = CW + F;
   localparam int RW = DW + 1;
   localparam int PW = 2 * D + 1;
   localparam int EW = (DW > D + 3 * F + 1) ? DW : D + 3 * F + 1;

   localparam logic [D-1:0] HI_D  = {1'b0, {(D-1){1'b1}}};
   localparam logic [D-1:0] LO_D  = {1'b1, {(D-1){1'b0}}};
   localparam logic [D-1:0] ONE_D = (F < D - 1) ? (D'(1) << F) : HI_D;
   localparam logic [NW-1:0] MAG_POS = (NW'(1) << (D - 1)) - NW'(1);
   localparam logic [NW-1:0] MAG_NEG = NW'(1) << (D - 1);
   localparam logic signed [EW-1:0] POS_LIM = EW'(1) << (D - 1 + 3 * F);
   localparam logic signed [EW-1:0] NEG_LIM =
      EW'(0) - (EW'(1) << (D - 1 + 3 * F)) - (EW'(1) << (3 * F));

   logic signed [D-1:0]   mat_ff [16];
   logic signed [CW-1:0]  cof_ff [16];
   logic signed [D-1:0]   ea_ff;
   logic signed [2*D-1:0] prod1_ff;
   logic signed [PW-1:0]  preg_ff;
   logic [1:0]            pshift_ff;
   logic                  psign_ff;
   logic signed [CW-1:0]  acc_ff;
   logic signed [DW-1:0]  det_ff;
   logic                  fb_ff;
   logic [NW-1:0]         num_ff;
   logic [RW-1:0]         rem_ff;
   logic [DW-1:0]         den_ff;
   logic                  qneg_ff;
   logic [D-1:0]          val_ff;
   logic [3:0]            idx_ff;
   logic                  last_ff;
   logic                  fbo_ff;

   logic signed [D-1:0]   e_rd;
   logic signed [CW-1:0]  c_rd;
   logic signed [D:0]     mul_a;
   logic signed [PW-1:0]  mul_p;
   logic signed [CW-1:0]  pc;
   logic signed [DW-1:0]  pd;
   logic signed [EW-1:0]  det_e;
   logic signed [NW-1:0]  nsh;
   logic [RW-1:0]         rsh;
   logic [NW-1:0]         qneg_v;
   logic [D-1:0]          sat_v;

   assign e_rd = mat_ff[cmd.idx];
   assign c_rd = cof_ff[cmd.cidx];

   always_comb begin
      case (cmd.op)
         OP_MUL_AB: mul_a = {ea_ff[D-1], ea_ff};
         OP_MUL_C:  mul_a = (cmd.part == 2'd0) ? {1'b0, prod1_ff[D-1:0]} :
                                                {prod1_ff[2*D-1], prod1_ff[2*D-1:D]};
         OP_MUL_D: begin
            // low chunks unsigned, the top chunk carries the sign
            if (cmd.part == 2'd3) mul_a = {{(D-1){c_rd[CW-1]}}, c_rd[CW-1:3*D]};
            else                  mul_a = {1'b0, c_rd[cmd.part*D +: D]};
         end
         default:   mul_a = {ea_ff[D-1], ea_ff};
      endcase
   end

   assign mul_p = mul_a * e_rd;
   assign pc    = CW'(preg_ff) <<< (pshift_ff[0] ? D : 0);
   assign pd    = DW'(preg_ff) <<< (int'(pshift_ff) * D);
   assign det_e = EW'(det_ff);
   assign nsh   = NW'(c_rd) <<< F;
   assign rsh   = {rem_ff[RW-2:0], num_ff[NW-1]};

   always_comb begin
      qneg_v = NW'(0) - num_ff;
      if (!qneg_ff) sat_v = (num_ff > MAG_POS) ? HI_D : num_ff[D-1:0];
      else          sat_v = (num_ff > MAG_NEG) ? LO_D : qneg_v[D-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mat_ff[cmd.idx] <= elem_in;
      if (cmd.acc_en)  acc_ff <= psign_ff ? acc_ff - pc : acc_ff + pc;
      if (cmd.dacc_en) det_ff <= det_ff + pd;
      if (cmd.clr) begin
         acc_ff <= '0;
         det_ff <= '0;
      end
      case (cmd.op)
         OP_LOAD_A: ea_ff    <= e_rd;
         OP_MUL_AB: prod1_ff <= mul_p[2*D-1:0];
         OP_MUL_C, OP_MUL_D: begin
            preg_ff   <= mul_p;
            pshift_ff <= cmd.part;
            psign_ff  <= cmd.neg;
         end
         OP_COF_WR: begin
            cof_ff[cmd.cidx] <= acc_ff;
            acc_ff           <= '0;
         end
         OP_DIV_INIT: begin
            num_ff  <= nsh[NW-1] ? NW'(-nsh) : NW'(nsh);
            rem_ff  <= '0;
            den_ff  <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
            qneg_ff <= nsh[NW-1] ^ det_ff[DW-1];
         end
         OP_DIV_STEP: begin
            if (rsh >= {1'b0, den_ff}) begin
               rem_ff <= rsh - {1'b0, den_ff};
               num_ff <= {num_ff[NW-2:0], 1'b1};
            end else begin
               rem_ff <= rsh;
               num_ff <= {num_ff[NW-2:0], 1'b0};
            end
         end
         OP_OUT: begin
            if (fb_ff) val_ff <= (cmd.idx[3:2] == cmd.idx[1:0]) ? ONE_D : '0;
            else       val_ff <= sat_v;
            idx_ff  <= cmd.idx;
            last_ff <= cmd.last;
            fbo_ff  <= fb_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff <= 1'b0;
      end else if (cmd.op == OP_CHK) begin
         fb_ff <= (det_ff == '0) || (det_e >= POS_LIM) || (det_e <= NEG_LIM);
      end
   end

   assign status.fell_back = fb_ff;
   assign inv_value        = val_ff;
   assign inv_index        = idx_ff;
   assign last_elem        = last_ff;
   assign fell_back        = fbo_ff;

endmodule
